/* rtl/dres_pkg.sv */
// Package for the dual-rate shape filter: config register codes, item and
// config types, counter and weight helpers. No dependencies.
package dres_pkg;

  localparam int FIELD_BITS    = 16;
  localparam int ALPHA_BITS    = 17;
  localparam int LIMIT_BITS    = 18;
  localparam int CNT_BITS      = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 18;

  localparam logic [ALPHA_BITS-1:0] ONE_Q16 = ALPHA_BITS'(65536);
  localparam logic [CNT_BITS-1:0]   CNT_MAX = '1;
  localparam logic [CNT_BITS-1:0]   INTERRUPT_LIMIT = CNT_BITS'(2);

  typedef enum logic [1:0] {
    FUNC_NOISY  = 2'd0,
    FUNC_NORMAL = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WT_FAR          = 3'd0,
    REG_WT_NEAR         = 3'd1,
    REG_VARIATION_LIMIT = 3'd2,
    REG_STREAK_NEEDED   = 3'd3,
    REG_NOISY_NEEDED    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [ALPHA_BITS-1:0] wt_far;
    logic [ALPHA_BITS-1:0] wt_near;
    logic [LIMIT_BITS-1:0] variation_limit;
    logic [CNT_BITS-1:0]   streak_needed;
    logic [CNT_BITS-1:0]   noisy_needed;
  } cfg_t;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + CNT_BITS'(1);
  endfunction

  function automatic logic [ALPHA_BITS-1:0] alpha_sat(input logic [ALPHA_BITS-1:0] a);
    return (a > ONE_Q16) ? ONE_Q16 : a;
  endfunction

endpackage

/* rtl/dres_if.sv */
// Valid/ready channel interfaces for the shape filter input and result.
// Depends on nothing.
interface dres_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        shape_is_box;
  logic [15:0] meas_length;
  logic [15:0] meas_width;
  logic [15:0] meas_height;

  modport source (output valid, func, shape_is_box, meas_length, meas_width, meas_height,
                  input ready);
  modport sink   (input valid, func, shape_is_box, meas_length, meas_width, meas_height,
                  output ready);
endinterface

interface dres_out_if;
  logic        valid;
  logic        ready;
  logic        out_is_box;
  logic [15:0] out_length;
  logic [15:0] out_width;
  logic [15:0] out_height;
  logic        is_stable;

  modport source (output valid, out_is_box, out_length, out_width, out_height, is_stable,
                  input ready);
  modport sink   (input valid, out_is_box, out_length, out_width, out_height, is_stable,
                  output ready);
endinterface

/* rtl/dres_lane.sv */
// One dimension lane: relative closeness test and both blend candidates.
// Depends on dres_pkg.
module dres_lane #(
  parameter int DIM_BITS = 16
) (
  input  logic [DIM_BITS-1:0]            meas,
  input  logic [DIM_BITS-1:0]            avg,
  input  logic [dres_pkg::ALPHA_BITS-1:0] wt_near,
  input  logic [dres_pkg::ALPHA_BITS-1:0] wt_far,
  input  logic [dres_pkg::LIMIT_BITS-1:0] limit,
  output logic                            close,
  output logic [DIM_BITS-1:0]            blend_strong,
  output logic [DIM_BITS-1:0]            blend_weak
);

  localparam int CW = DIM_BITS + dres_pkg::LIMIT_BITS;
  localparam int AW = DIM_BITS + 19;

  logic [DIM_BITS-1:0] dev;
  logic [DIM_BITS-1:0] base;
  logic [CW-1:0]       lhs;
  logic [CW-1:0]       rhs;

  logic signed [DIM_BITS:0] diff;
  logic signed [AW-1:0]     avg_sh;
  logic signed [AW-1:0]     prod_s;
  logic signed [AW-1:0]     prod_w;
  logic signed [AW-1:0]     acc_s;
  logic signed [AW-1:0]     acc_w;

  always_comb begin
    dev  = (meas > avg) ? meas - avg : avg - meas;
    base = (avg > DIM_BITS'(1)) ? avg : DIM_BITS'(1);
    lhs  = CW'({dev, 16'h0000});
    rhs  = CW'(limit) * CW'(base);
    close = lhs < rhs;
  end

  // v' = v + a*(m - v), rounded half up
  always_comb begin
    diff   = $signed({1'b0, meas}) - $signed({1'b0, avg});
    avg_sh = $signed(AW'({avg, 16'h0000}));
    prod_s = $signed({1'b0, wt_near}) * diff;
    prod_w = $signed({1'b0, wt_far}) * diff;
    acc_s  = avg_sh + prod_s + $signed(AW'(32768));
    acc_w  = avg_sh + prod_w + $signed(AW'(32768));
    blend_strong = acc_s[DIM_BITS+15:16];
    blend_weak   = acc_w[DIM_BITS+15:16];
  end

endmodule

/* rtl/dual_rate_ema_shape_filter.sv */
// Top level of the dual-rate shape filter: input register, filter state,
// result register. Depends on dres_pkg, dres_if, dres_lane.
//
//  channel  | dir | transfer when       | payload
//  in_ch    | in  | valid && ready      | func, shape_is_box, meas_length/width/height
//  out_ch   | out | valid && ready      | out_is_box, out_length/width/height, is_stable
//  cfg_*    | in  | cfg_we              | cfg_index, cfg_wdata
//
// One item per cycle sustained while out_ch is ready; an item passes through the input register
// and then the result register. The state update (closeness test and blend per lane) is
// combinational between the input register and the result register.
// Synchronous active-low reset; no clearing pass.
// A stalled result holds its register; input keeps flowing until both stages are full.
module dual_rate_ema_shape_filter #(
  parameter int DIM_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  dres_in_if.sink                              in_ch,
  dres_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [dres_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [dres_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam int FB = dres_pkg::FIELD_BITS;
  localparam int XW = (DIM_BITS > FB) ? DIM_BITS : FB;

  typedef logic [DIM_BITS-1:0] dim_t;

  dres_pkg::cfg_t cfg_r;

  // input stage
  logic             in_v_r;
  dres_pkg::func_t  func_r;
  logic             box_in_r;
  dim_t             meas_r [3];

  // filter state
  logic                        seeded_r, seeded_nxt;
  logic                        stable_r, stable_nxt;
  dim_t                        avg_r [3];
  dim_t                        avg_nxt [3];
  logic [dres_pkg::CNT_BITS-1:0] streak_r, streak_nxt;
  logic [dres_pkg::CNT_BITS-1:0] noisy_r, noisy_nxt;
  logic [dres_pkg::CNT_BITS-1:0] intr_r, intr_nxt;
  logic                        lbox_r, lbox_nxt;
  dim_t                        ldim_r [3];
  dim_t                        ldim_nxt [3];

  // result stage
  logic        out_v_r;
  logic        res_box_r;
  logic [FB-1:0] res_dim_r [3];
  logic        res_stable_r;

  logic adv, fire;
  logic [2:0] close_v;
  dim_t bl_s [3];
  dim_t bl_w [3];
  logic [dres_pkg::ALPHA_BITS-1:0] a_s, a_w;
  logic all_close;
  logic [XW-1:0] meas_x [3];
  logic [XW-1:0] res_x [3];
  logic [dres_pkg::CNT_BITS-1:0] noisy_inc, streak_inc, intr_inc;

  assign adv = !out_v_r || out_ch.ready;
  assign fire = in_v_r && adv;
  assign in_ch.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wt_far          <= dres_pkg::ALPHA_BITS'(6554);
      cfg_r.wt_near         <= dres_pkg::ALPHA_BITS'(32768);
      cfg_r.variation_limit <= dres_pkg::LIMIT_BITS'(6554);
      cfg_r.streak_needed   <= dres_pkg::CNT_BITS'(3);
      cfg_r.noisy_needed    <= dres_pkg::CNT_BITS'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        dres_pkg::REG_WT_FAR:
          cfg_r.wt_far <= cfg_wdata[dres_pkg::ALPHA_BITS-1:0];
        dres_pkg::REG_WT_NEAR:
          cfg_r.wt_near <= cfg_wdata[dres_pkg::ALPHA_BITS-1:0];
        dres_pkg::REG_VARIATION_LIMIT:
          cfg_r.variation_limit <= cfg_wdata[dres_pkg::LIMIT_BITS-1:0];
        dres_pkg::REG_STREAK_NEEDED:
          cfg_r.streak_needed <= cfg_wdata[dres_pkg::CNT_BITS-1:0];
        dres_pkg::REG_NOISY_NEEDED:
          cfg_r.noisy_needed <= cfg_wdata[dres_pkg::CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    meas_x[0] = XW'(in_ch.meas_length);
    meas_x[1] = XW'(in_ch.meas_width);
    meas_x[2] = XW'(in_ch.meas_height);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r   <= dres_pkg::func_t'(in_ch.func);
      box_in_r <= in_ch.shape_is_box;
      for (int i = 0; i < 3; i++) begin
        meas_r[i] <= meas_x[i][DIM_BITS-1:0];
      end
    end
  end

  assign a_s = dres_pkg::alpha_sat(cfg_r.wt_near);
  assign a_w = dres_pkg::alpha_sat(cfg_r.wt_far);

  for (genvar g = 0; g < 3; g++) begin : g_lane
    dres_lane #(.DIM_BITS(DIM_BITS)) u_lane (
      .meas         (meas_r[g]),
      .avg          (avg_r[g]),
      .wt_near      (a_s),
      .wt_far       (a_w),
      .limit        (cfg_r.variation_limit),
      .close        (close_v[g]),
      .blend_strong (bl_s[g]),
      .blend_weak   (bl_w[g])
    );
  end

  assign all_close  = &close_v;
  assign noisy_inc  = dres_pkg::sat_inc(noisy_r);
  assign streak_inc = dres_pkg::sat_inc(streak_r);
  assign intr_inc   = dres_pkg::sat_inc(intr_r);

  always_comb begin
    seeded_nxt = seeded_r;
    stable_nxt = stable_r;
    streak_nxt = streak_r;
    noisy_nxt  = noisy_r;
    intr_nxt   = intr_r;
    lbox_nxt   = lbox_r;
    for (int i = 0; i < 3; i++) begin
      avg_nxt[i]  = avg_r[i];
      ldim_nxt[i] = ldim_r[i];
    end
    case (func_r)
      dres_pkg::FUNC_NOISY: begin
        lbox_nxt = box_in_r;
        for (int i = 0; i < 3; i++) begin
          ldim_nxt[i] = meas_r[i];
        end
        if (box_in_r && !seeded_r) begin
          seeded_nxt = 1'b1;
          stable_nxt = 1'b0;
          streak_nxt = '0;
          for (int i = 0; i < 3; i++) begin
            avg_nxt[i] = meas_r[i];
          end
        end else if (box_in_r) begin
          noisy_nxt = noisy_inc;
          intr_nxt  = '0;
          if (all_close) begin
            streak_nxt = streak_inc;
            if (streak_inc >= cfg_r.streak_needed && noisy_inc >= cfg_r.noisy_needed) begin
              stable_nxt = 1'b1;
            end
            for (int i = 0; i < 3; i++) begin
              avg_nxt[i] = bl_s[i];
            end
          end else begin
            streak_nxt = '0;
            stable_nxt = 1'b0;
            for (int i = 0; i < 3; i++) begin
              avg_nxt[i] = bl_w[i];
            end
          end
        end
      end
      dres_pkg::FUNC_NORMAL: begin
        intr_nxt = intr_inc;
        if (intr_inc >= dres_pkg::INTERRUPT_LIMIT) begin
          noisy_nxt  = '0;
          stable_nxt = 1'b0;
        end
      end
      dres_pkg::FUNC_CLEAR: begin
        seeded_nxt = 1'b0;
        stable_nxt = 1'b0;
        streak_nxt = '0;
        noisy_nxt  = '0;
        intr_nxt   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r <= 1'b0;
      stable_r <= 1'b0;
      streak_r <= '0;
      noisy_r  <= '0;
      intr_r   <= '0;
      lbox_r   <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        avg_r[i]  <= '0;
        ldim_r[i] <= '0;
      end
    end else if (fire) begin
      seeded_r <= seeded_nxt;
      stable_r <= stable_nxt;
      streak_r <= streak_nxt;
      noisy_r  <= noisy_nxt;
      intr_r   <= intr_nxt;
      lbox_r   <= lbox_nxt;
      for (int i = 0; i < 3; i++) begin
        avg_r[i]  <= avg_nxt[i];
        ldim_r[i] <= ldim_nxt[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_x[i] = XW'(lbox_nxt ? avg_nxt[i] : ldim_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_box_r    <= lbox_nxt;
      res_stable_r <= stable_nxt;
      for (int i = 0; i < 3; i++) begin
        res_dim_r[i] <= res_x[i][FB-1:0];
      end
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_is_box = res_box_r;
  assign out_ch.out_length = res_dim_r[0];
  assign out_ch.out_width  = res_dim_r[1];
  assign out_ch.out_height = res_dim_r[2];
  assign out_ch.is_stable  = res_stable_r;

  a_stable_needs_seed: assert property (@(posedge clk) disable iff (!rst_n)
    stable_r |-> seeded_r)
    else $error("stable flag set without a seeded average");

  a_streak_needs_seed: assert property (@(posedge clk) disable iff (!rst_n)
    !seeded_r |-> (streak_r == '0))
    else $error("streak count nonzero while unseeded");

  a_intr_drops_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (intr_r >= dres_pkg::INTERRUPT_LIMIT) |-> !stable_r)
    else $error("stable flag held past the interruption limit");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_v_r)
    else $error("processed item produced no result");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !adv) |=> in_v_r)
    else $error("stalled input stage lost its item");

endmodule

/* tb/sv/dual_rate_ema_shape_filter_tb.sv */
// Self-checking testbench for dual_rate_ema_shape_filter: directed and random
// shape items with random idling on both channels, checked by a local predictor.
// Depends on dres_pkg, dres_if and the filter RTL.
module dual_rate_ema_shape_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dres_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PRINT_CAP    = 100;
  localparam logic [CFG_IDX_BITS-1:0] SPARE_REG_IDX = CFG_IDX_BITS'(7);

  typedef struct packed {
    func_t                      func;
    logic                       box;
    logic [2:0][FIELD_BITS-1:0] dims;
    logic                       drain_first;
  } shape_item_t;

  typedef struct packed {
    logic                       box;
    logic [2:0][FIELD_BITS-1:0] dims;
    logic                       stable;
  } shape_result_t;

  logic clk;
  logic rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  dres_in_if  in_ch_if ();
  dres_out_if out_ch_if ();

  dual_rate_ema_shape_filter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch_if),
    .out_ch    (out_ch_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  shape_item_t   pending_items [$];
  shape_result_t expected_shapes [$];
  shape_item_t   cur_item;
  int            mismatch_count = 0;

  // filter state as predicted
  cfg_t                       filt_cfg;
  logic                       seeded_q, stable_q, latest_box_q;
  logic [2:0][FIELD_BITS-1:0] smooth_q, latest_q;
  logic [CNT_BITS-1:0]        streak_q, noisy_q, intr_q;

  bit in_free;
  int in_gap = 0;
  bit in_steady = 1'b0;
  int out_hold = 0;
  bit out_steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [CNT_BITS-1:0] count_up(input logic [CNT_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic [FIELD_BITS-1:0] mix(input logic [ALPHA_BITS-1:0] a_raw,
                                                 input logic [FIELD_BITS-1:0] m,
                                                 input logic [FIELD_BITS-1:0] v);
    longint unsigned a, acc;
    a = (a_raw > ONE_Q16) ? ONE_Q16 : a_raw;
    acc = a * m + (ONE_Q16 - a) * v + 32768;
    return FIELD_BITS'(acc >> 16);
  endfunction

  function automatic bit near(input logic [FIELD_BITS-1:0] m, input logic [FIELD_BITS-1:0] v,
                              input logic [LIMIT_BITS-1:0] lim);
    longint unsigned d, base;
    d = (m > v) ? m - v : v - m;
    base = (v > 1) ? v : 1;
    return (d << 16) < lim * base;
  endfunction

  function automatic shape_result_t advance_shape_filter(input shape_item_t it);
    shape_result_t r;
    bit close;
    int i;
    case (it.func)
      FUNC_NOISY: begin
        latest_box_q = it.box;
        latest_q = it.dims;
        if (it.box && !seeded_q) begin
          smooth_q = it.dims;
          seeded_q = 1'b1;
          stable_q = 1'b0;
          streak_q = '0;
        end else if (it.box) begin
          noisy_q = count_up(noisy_q);
          intr_q = '0;
          close = 1'b1;
          for (i = 0; i < 3; i++)
            if (!near(it.dims[i], smooth_q[i], filt_cfg.variation_limit)) close = 1'b0;
          if (close) begin
            for (i = 0; i < 3; i++) smooth_q[i] = mix(filt_cfg.wt_near, it.dims[i], smooth_q[i]);
            streak_q = count_up(streak_q);
            if (streak_q >= filt_cfg.streak_needed && noisy_q >= filt_cfg.noisy_needed)
              stable_q = 1'b1;
          end else begin
            streak_q = '0;
            stable_q = 1'b0;
            for (i = 0; i < 3; i++) smooth_q[i] = mix(filt_cfg.wt_far, it.dims[i], smooth_q[i]);
          end
        end
      end
      FUNC_NORMAL: begin
        intr_q = count_up(intr_q);
        if (intr_q >= INTERRUPT_LIMIT) begin
          noisy_q = '0;
          stable_q = 1'b0;
        end
      end
      FUNC_CLEAR: begin
        seeded_q = 1'b0;
        stable_q = 1'b0;
        streak_q = '0;
        noisy_q = '0;
        intr_q = '0;
      end
      default: ;
    endcase
    r.box = latest_box_q;
    r.dims = latest_box_q ? smooth_q : latest_q;
    r.stable = stable_q;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t ns: bad %s, got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result();
    shape_result_t want;
    if (expected_shapes.size() == 0) begin
      flag_mismatch("result with nothing pending", out_ch_if.out_length, 0);
    end else begin
      want = expected_shapes.pop_front();
      if (out_ch_if.out_is_box !== want.box)
        flag_mismatch("out_is_box", out_ch_if.out_is_box, want.box);
      if (out_ch_if.out_length !== want.dims[0])
        flag_mismatch("out_length", out_ch_if.out_length, want.dims[0]);
      if (out_ch_if.out_width !== want.dims[1])
        flag_mismatch("out_width", out_ch_if.out_width, want.dims[1]);
      if (out_ch_if.out_height !== want.dims[2])
        flag_mismatch("out_height", out_ch_if.out_height, want.dims[2]);
      if (out_ch_if.is_stable !== want.stable)
        flag_mismatch("is_stable", out_ch_if.is_stable, want.stable);
    end
  endtask

  // driver: one transfer per item, random gap drawn after each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch_if.valid <= 1'b0;
    end else begin
      in_free = !in_ch_if.valid;
      if (in_ch_if.valid && in_ch_if.ready) begin
        expected_shapes.push_back(advance_shape_filter(cur_item));
        in_free = 1'b1;
        if ($urandom_range(0, 59) == 0) in_steady = !in_steady;
        in_gap = in_steady ? 0 : $urandom_range(0, 10);
      end
      if (in_free) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch_if.valid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].drain_first || expected_shapes.size() == 0)) begin
          cur_item = pending_items.pop_front();
          in_ch_if.func         <= cur_item.func;
          in_ch_if.shape_is_box <= cur_item.box;
          in_ch_if.meas_length  <= cur_item.dims[0];
          in_ch_if.meas_width   <= cur_item.dims[1];
          in_ch_if.meas_height  <= cur_item.dims[2];
          in_ch_if.valid        <= 1'b1;
        end else begin
          in_ch_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer, then stalls a waiting result at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch_if.ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_ch_if.valid && out_ch_if.ready) begin
        check_result();
        if ($urandom_range(0, 59) == 0) out_steady = !out_steady;
        out_hold = out_steady ? 0 : $urandom_range(0, 10);
      end else if (out_hold > 0 && out_ch_if.valid) begin
        out_hold--;
      end
      out_ch_if.ready <= (out_hold == 0);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch_if.valid && in_ch_if.ready) || (out_ch_if.valid && out_ch_if.ready))
        idle = 0;
      else
        idle++;
    end
    $display("dual_rate_ema_shape_filter: mismatch");
    $finish;
  end

  task automatic push_item(input func_t f, input logic box, input int l, input int w,
                           input int h, input bit drain = 1'b0);
    shape_item_t it;
    it.func = f;
    it.box = box;
    it.dims[0] = FIELD_BITS'(l);
    it.dims[1] = FIELD_BITS'(w);
    it.dims[2] = FIELD_BITS'(h);
    it.drain_first = drain;
    pending_items.push_back(it);
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch_if.valid || expected_shapes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_WT_FAR:          filt_cfg.wt_far          = data[ALPHA_BITS-1:0];
      REG_WT_NEAR:         filt_cfg.wt_near         = data[ALPHA_BITS-1:0];
      REG_VARIATION_LIMIT: filt_cfg.variation_limit = data[LIMIT_BITS-1:0];
      REG_STREAK_NEEDED:   filt_cfg.streak_needed   = data[CNT_BITS-1:0];
      REG_NOISY_NEEDED:    filt_cfg.noisy_needed    = data[CNT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CFG_DATA_BITS-1:0] aw, input logic [CFG_DATA_BITS-1:0] as,
                                input logic [CFG_DATA_BITS-1:0] lim,
                                input logic [CFG_DATA_BITS-1:0] sn,
                                input logic [CFG_DATA_BITS-1:0] nn, input bit spare = 1'b0);
    wait_drain();
    write_reg(REG_WT_FAR, aw);
    write_reg(REG_WT_NEAR, as);
    write_reg(REG_VARIATION_LIMIT, lim);
    write_reg(REG_STREAK_NEEDED, sn);
    write_reg(REG_NOISY_NEEDED, nn);
    if (spare) write_reg(SPARE_REG_IDX, CFG_DATA_BITS'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_settings(input bit spare);
    logic [CFG_DATA_BITS-1:0] aw, as, lim, sn, nn;
    aw  = ($urandom_range(0, 4) == 0) ? CFG_DATA_BITS'($urandom)
                                      : CFG_DATA_BITS'($urandom_range(0, ONE_Q16));
    as  = ($urandom_range(0, 4) == 0) ? CFG_DATA_BITS'($urandom)
                                      : CFG_DATA_BITS'($urandom_range(0, ONE_Q16));
    lim = ($urandom_range(0, 3) == 0) ? CFG_DATA_BITS'($urandom)
                                      : CFG_DATA_BITS'($urandom_range(0, 20000));
    sn  = {10'($urandom), ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6))};
    nn  = {10'($urandom), ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6))};
    apply_settings(aw, as, lim, sn, nn, spare);
  endtask

  function automatic logic [2:0][FIELD_BITS-1:0] pick_base();
    logic [2:0][FIELD_BITS-1:0] b;
    int style, i;
    style = $urandom_range(0, 9);
    for (i = 0; i < 3; i++) begin
      if (style < 3)      b[i] = FIELD_BITS'($urandom_range(0, 40));
      else if (style < 8) b[i] = FIELD_BITS'($urandom_range(50, 3000));
      else                b[i] = FIELD_BITS'($urandom_range(0, 65535));
    end
    return b;
  endfunction

  function automatic logic [2:0][FIELD_BITS-1:0] jitter(input logic [2:0][FIELD_BITS-1:0] base,
                                                        input int max_pct);
    logic [2:0][FIELD_BITS-1:0] d;
    int i, off, val;
    for (i = 0; i < 3; i++) begin
      off = (int'(base[i]) * $urandom_range(0, max_pct)) / 100 + $urandom_range(0, 1);
      val = $urandom_range(0, 1) ? int'(base[i]) + off : int'(base[i]) - off;
      if (val < 0) val = 0;
      if (val > 65535) val = 65535;
      d[i] = FIELD_BITS'(val);
    end
    return d;
  endfunction

  // mostly box measurements jittered around a base shape that is re-picked at random, with frames,
  // clears, non-box shapes, unused codes and outliers mixed in
  task automatic queue_track(input int count, input int max_pct);
    logic [2:0][FIELD_BITS-1:0] base;
    shape_item_t it;
    int sel, k;
    base = pick_base();
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      it.func = FUNC_NOISY;
      it.box = 1'b1;
      it.dims = {16'($urandom), 16'($urandom), 16'($urandom)};
      it.drain_first = ($urandom_range(0, 99) == 0);
      if (sel < 66) begin
        it.dims = jitter(base, max_pct);
      end else if (sel < 76) begin
        it.func = FUNC_NORMAL;
        it.box = 1'($urandom_range(0, 1));
      end else if (sel < 81) begin
        it.box = 1'b0;
      end else if (sel < 84) begin
        it.func = FUNC_CLEAR;
        it.box = 1'($urandom_range(0, 1));
      end else if (sel < 87) begin
        it.func = FUNC_NONE;
        it.box = 1'($urandom_range(0, 1));
      end else if (sel >= 92) begin
        base = pick_base();
        it.dims = base;
      end
      pending_items.push_back(it);
    end
  endtask

  // long close run to saturate streak and noisy counts, then a long run of
  // frames to saturate the interruption count
  task automatic queue_steady();
    logic [2:0][FIELD_BITS-1:0] base, d;
    int k;
    base[0] = FIELD_BITS'($urandom_range(1000, 5000));
    base[1] = FIELD_BITS'($urandom_range(1000, 5000));
    base[2] = FIELD_BITS'($urandom_range(1000, 5000));
    push_item(FUNC_CLEAR, 1'b1, 0, 0, 0);
    for (k = 0; k < 300; k++) begin
      d = jitter(base, 1);
      push_item(FUNC_NOISY, 1'b1, d[0], d[1], d[2]);
    end
    for (k = 0; k < 280; k++) push_item(FUNC_NORMAL, 1'($urandom_range(0, 1)), 0, 0, 0);
    for (k = 0; k < 5; k++) begin
      d = jitter(base, 1);
      push_item(FUNC_NOISY, 1'b1, d[0], d[1], d[2]);
    end
  endtask

  initial begin
    int p;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch_if.valid = 1'b0;
    in_ch_if.func = FUNC_NOISY;
    in_ch_if.shape_is_box = 1'b0;
    in_ch_if.meas_length = '0;
    in_ch_if.meas_width = '0;
    in_ch_if.meas_height = '0;
    out_ch_if.ready = 1'b0;

    filt_cfg.wt_far = ALPHA_BITS'(6554);
    filt_cfg.wt_near = ALPHA_BITS'(32768);
    filt_cfg.variation_limit = LIMIT_BITS'(6554);
    filt_cfg.streak_needed = CNT_BITS'(3);
    filt_cfg.noisy_needed = CNT_BITS'(3);
    seeded_q = 1'b0;
    stable_q = 1'b0;
    latest_box_q = 1'b1;
    smooth_q = '0;
    latest_q = '0;
    streak_q = '0;
    noisy_q = '0;
    intr_q = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, at reset settings
    push_item(FUNC_NORMAL, 1'b0, 0, 0, 0);
    push_item(FUNC_NONE, 1'b1, 65535, 65535, 65535);
    push_item(FUNC_CLEAR, 1'b0, 0, 0, 0);
    push_item(FUNC_NOISY, 1'b0, 65535, 65535, 65535);
    push_item(FUNC_NOISY, 1'b1, 1000, 500, 200);
    push_item(FUNC_NOISY, 1'b1, 1010, 505, 201);
    push_item(FUNC_NOISY, 1'b1, 995, 498, 199);
    push_item(FUNC_NOISY, 1'b1, 1005, 502, 200);
    push_item(FUNC_NORMAL, 1'b1, 0, 0, 0);
    push_item(FUNC_NOISY, 1'b1, 1000, 500, 200);
    push_item(FUNC_NORMAL, 1'b1, 0, 0, 0);
    push_item(FUNC_NORMAL, 1'b1, 0, 0, 0);
    push_item(FUNC_NOISY, 1'b1, 0, 0, 0);
    push_item(FUNC_NOISY, 1'b1, 65535, 0, 65535);
    push_item(FUNC_NOISY, 1'b1, 0, 0, 0, 1'b1);
    push_item(FUNC_CLEAR, 1'b1, 0, 0, 0);
    push_item(FUNC_NOISY, 1'b1, 65535, 65535, 65535);
    push_item(FUNC_NOISY, 1'b1, 65535, 65535, 65535);
    push_item(FUNC_NOISY, 1'b0, 0, 0, 0);
    push_item(FUNC_NONE, 1'b0, 12345, 43690, 21845);
    push_item(FUNC_CLEAR, 1'b1, 0, 0, 0);
    push_item(FUNC_NOISY, 1'b1, 0, 0, 0);
    push_item(FUNC_NOISY, 1'b1, 0, 0, 1);
    push_item(FUNC_NOISY, 1'b1, 0, 0, 0);

    apply_settings(0, ONE_Q16, 6554, 3, 3);
    queue_track(150, 12);
    apply_settings(18'h3FFFF, 65537, 18'h3FFFF, 0, 0);
    queue_track(150, 12);
    apply_settings(ONE_Q16, 0, 0, 255, 255);
    queue_track(150, 12);
    apply_settings(6554, 32768, 6554, 255, 255);
    queue_steady();
    for (p = 0; p < 5; p++) begin
      random_settings(p == 0);
      queue_track(150, $urandom_range(1, 15));
    end

    wait_drain();
    if (mismatch_count == 0)
      $display("dual_rate_ema_shape_filter: match");
    else
      $display("dual_rate_ema_shape_filter: mismatch");
    $finish;
  end

endmodule

/* sim.f */
rtl/dres_pkg.sv
rtl/dres_if.sv
rtl/dres_lane.sv
rtl/dual_rate_ema_shape_filter.sv
tb/sv/dual_rate_ema_shape_filter_tb.sv
